// ===== rtl/segment_intersection_distance_unit_defines.svh =====
// assertion macros for the segment intersection distance unit
`ifndef SEGMENT_INTERSECTION_DISTANCE_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_DISTANCE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SIDU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sidu assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SIDU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sidu assertion failed");

`endif

// ===== rtl/sidu_pkg.sv =====
// shared constants for the segment intersection distance unit
package sidu_pkg;

  // width of one signed fixed-point coordinate
  localparam int unsigned COORD_BITS = 24;

endpackage

// ===== rtl/sidu_in_if.sv =====
// input and output channel interfaces of the segment intersection distance unit
interface sidu_in_if #(
  parameter int unsigned CoordBits = sidu_pkg::COORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] a_start_x;
  logic signed [CoordBits-1:0] a_start_y;
  logic signed [CoordBits-1:0] a_end_x;
  logic signed [CoordBits-1:0] a_end_y;
  logic signed [CoordBits-1:0] b_start_x;
  logic signed [CoordBits-1:0] b_start_y;
  logic signed [CoordBits-1:0] b_end_x;
  logic signed [CoordBits-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
    output b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
    input  b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface sidu_out_if #(
  parameter int unsigned CoordBits = sidu_pkg::COORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic signed [CoordBits-1:0] cross_x;
  logic signed [CoordBits-1:0] cross_y;
  logic        [CoordBits:0]   dist_from_start;

  modport source (
    output valid, hit, cross_x, cross_y, dist_from_start,
    input  ready
  );
  modport sink (
    input  valid, hit, cross_x, cross_y, dist_from_start,
    output ready
  );
endinterface

// ===== rtl/sidu_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module sidu_div #(
  parameter int unsigned W = sidu_pkg::COORD_BITS + 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [3*W-1:0]   num_i,
  input  logic [2*W-1:0]   den_i,
  output logic [W-1:0]     quo_o
);
  localparam int unsigned NW = 3 * W;
  localparam int unsigned DW = 2 * W;

  logic [NW-1:0] rem_q [W];
  logic [DW-1:0] den_q [W];
  logic [W-1:0]  quo_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int unsigned Sh = W - 1 - k;
    logic [NW-1:0] rem_in, trial, rem_d;
    logic [DW-1:0] den_in;
    logic [W-1:0]  quo_in, quo_d;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {{W{1'b0}}, den_in} << Sh;

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        quo_d = quo_in | ({{(W-1){1'b0}}, 1'b1} << Sh);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[W-1];
endmodule

// ===== rtl/sidu_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module sidu_sqrt #(
  parameter int unsigned W = sidu_pkg::COORD_BITS + 1
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*W-1:0] sq_i,
  output logic [W-1:0]   root_o
);
  localparam int unsigned RW = W + 3;

  logic [RW-1:0]  rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] sq_q   [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [RW-1:0]  rem_in, rem_sh, trial, rem_d;
    logic [W-1:0]   root_in, root_d;
    logic [2*W-1:0] sq_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sq_in   = sq_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sq_in   = sq_q[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], sq_in[2*W-1-2*k -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_comb begin
      rem_d  = rem_sh;
      root_d = {root_in[W-2:0], 1'b0};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[W-2:0], 1'b1};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        sq_q[k]   <= sq_in;
      end
    end
  end

  assign root_o = root_q[W-1];
endmodule

// ===== rtl/segment_intersection_distance_unit.sv =====
// throughput: one beat per cycle; the pipeline stalls as a whole only when out is held
// the depth comes from the bit-per-stage divider and square root, COORD_BITS+1 stages each
// reset: rst_ni low clears all stage valid bits at once; datapath registers are not reset
// a stall freezes every stage, so no beat is lost or repeated
`include "segment_intersection_distance_unit_defines.svh"

module segment_intersection_distance_unit #(
  parameter int unsigned COORD_BITS = sidu_pkg::COORD_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sidu_in_if.sink    in_i,
  sidu_out_if.source out_o
);
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned W  = C + 1;      // difference width
  localparam int unsigned P  = 2 * W;      // product width
  localparam int unsigned NS = 2 * W + 9;  // total register stages

  // stage indexes into the valid chain
  localparam int unsigned SDiv  = 6;
  localparam int unsigned SPost = SDiv + W;
  localparam int unsigned SOut  = NS - 1;

  logic [NS-1:0] vld_q;
  logic          adv;

  // whole pipe moves unless a finished beat is waiting at the output and out is not ready
  assign adv        = !vld_q[SOut] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_i.valid};
    end
  end

  // stage 1: direction and offset vectors
  logic signed [W-1:0] qax1_q, qay1_q, qbx1_q, qby1_q, dpx1_q, dpy1_q;
  logic signed [C-1:0] ax1_q, ay1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qax1_q <= {in_i.a_end_x[C-1], in_i.a_end_x} - {in_i.a_start_x[C-1], in_i.a_start_x};
      qay1_q <= {in_i.a_end_y[C-1], in_i.a_end_y} - {in_i.a_start_y[C-1], in_i.a_start_y};
      qbx1_q <= {in_i.b_end_x[C-1], in_i.b_end_x} - {in_i.b_start_x[C-1], in_i.b_start_x};
      qby1_q <= {in_i.b_end_y[C-1], in_i.b_end_y} - {in_i.b_start_y[C-1], in_i.b_start_y};
      dpx1_q <= {in_i.b_start_x[C-1], in_i.b_start_x} - {in_i.a_start_x[C-1], in_i.a_start_x};
      dpy1_q <= {in_i.b_start_y[C-1], in_i.b_start_y} - {in_i.a_start_y[C-1], in_i.a_start_y};
      ax1_q  <= in_i.a_start_x;
      ay1_q  <= in_i.a_start_y;
    end
  end

  // stage 2: the six cross products
  logic signed [P-1:0] pd0_q, pd1_q, pa0_q, pa1_q, pb0_q, pb1_q;
  logic signed [W-1:0] qax2_q, qay2_q;
  logic signed [C-1:0] ax2_q, ay2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd0_q  <= qay1_q * qbx1_q;
      pd1_q  <= qby1_q * qax1_q;
      pa0_q  <= qbx1_q * dpy1_q;
      pa1_q  <= qby1_q * dpx1_q;
      pb0_q  <= qax1_q * dpy1_q;
      pb1_q  <= qay1_q * dpx1_q;
      qax2_q <= qax1_q;
      qay2_q <= qay1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
    end
  end

  // stage 3: denominator and both numerators
  logic signed [P:0]   d3_q, na3_q, nb3_q;
  logic signed [W-1:0] qax3_q, qay3_q;
  logic signed [C-1:0] ax3_q, ay3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d3_q   <= {pd0_q[P-1], pd0_q} - {pd1_q[P-1], pd1_q};
      na3_q  <= {pa0_q[P-1], pa0_q} - {pa1_q[P-1], pa1_q};
      nb3_q  <= {pb0_q[P-1], pb0_q} - {pb1_q[P-1], pb1_q};
      qax3_q <= qax2_q;
      qay3_q <= qay2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
    end
  end

  // stage 4: fold the sign of d into the numerators, range tests on la and lb
  logic [P:0]   dn, nan, nbn;
  logic         hit4_d;
  logic [W-1:0] qxm4_d, qym4_d;

  always_comb begin
    dn  = d3_q[P] ? (~d3_q + 1'b1)  : d3_q;
    nan = d3_q[P] ? (~na3_q + 1'b1) : na3_q;
    nbn = d3_q[P] ? (~nb3_q + 1'b1) : nb3_q;
    // parallel or degenerate segments never hit; endpoints count
    hit4_d = (d3_q != '0) && !nan[P] && !nbn[P] && (nan <= dn) && (nbn <= dn);
    qxm4_d = qax3_q[W-1] ? (~qax3_q + 1'b1) : qax3_q;
    qym4_d = qay3_q[W-1] ? (~qay3_q + 1'b1) : qay3_q;
  end

  logic           hit4_q, sx4_q, sy4_q;
  logic [P-1:0]   dm4_q, nam4_q;
  logic [W-1:0]   qxm4_q, qym4_q;
  logic [C-1:0]   ax4_q, ay4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit4_q <= hit4_d;
      dm4_q  <= dn[P-1:0];
      nam4_q <= nan[P-1:0];
      qxm4_q <= qxm4_d;
      qym4_q <= qym4_d;
      sx4_q  <= qax3_q[W-1];
      sy4_q  <= qay3_q[W-1];
      ax4_q  <= ax3_q;
      ay4_q  <= ay3_q;
    end
  end

  // stage 5: na times |qa|, split into two narrow partial products per axis
  logic         hit5_q, sx5_q, sy5_q;
  logic [P-1:0] dm5_q, pxl5_q, pxh5_q, pyl5_q, pyh5_q;
  logic [C-1:0] ax5_q, ay5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxl5_q <= nam4_q[W-1:0] * qxm4_q;
      pxh5_q <= nam4_q[P-1:W] * qxm4_q;
      pyl5_q <= nam4_q[W-1:0] * qym4_q;
      pyh5_q <= nam4_q[P-1:W] * qym4_q;
      dm5_q  <= dm4_q;
      hit5_q <= hit4_q;
      sx5_q  <= sx4_q;
      sy5_q  <= sy4_q;
      ax5_q  <= ax4_q;
      ay5_q  <= ay4_q;
    end
  end

  // stage 6: recombine partial products into the dividends
  logic [3*W-1:0] numx6_q, numy6_q;
  logic [P-1:0]   dm6_q;

  typedef struct packed {
    logic         hit;
    logic         sx;
    logic         sy;
    logic [C-1:0] ax;
    logic [C-1:0] ay;
  } div_side_t;

  div_side_t side6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx6_q <= {{W{1'b0}}, pxl5_q} + {pxh5_q, {W{1'b0}}};
      numy6_q <= {{W{1'b0}}, pyl5_q} + {pyh5_q, {W{1'b0}}};
      dm6_q   <= dm5_q;
      side6_q <= '{hit: hit5_q, sx: sx5_q, sy: sy5_q, ax: ax5_q, ay: ay5_q};
    end
  end

  // divider stages, one per quotient bit, side data delayed alongside
  logic [W-1:0] qx, qy;

  sidu_div #(.W(W)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numx6_q),
    .den_i (dm6_q),
    .quo_o (qx)
  );

  sidu_div #(.W(W)) u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numy6_q),
    .den_i (dm6_q),
    .quo_o (qy)
  );

  div_side_t dside_q [W];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dside_q[0] <= side6_q;
      for (int unsigned k = 1; k < W; k++) begin
        dside_q[k] <= dside_q[k-1];
      end
    end
  end

  // post stage: intersection point and squared offsets
  logic [W:0]   posx, posy, offx, offy, sumx, sumy;
  logic [C-1:0] cx7_d, cy7_d;

  always_comb begin
    posx  = {1'b0, qx};
    posy  = {1'b0, qy};
    offx  = dside_q[W-1].sx ? (~posx + 1'b1) : posx;
    offy  = dside_q[W-1].sy ? (~posy + 1'b1) : posy;
    sumx  = {{2{dside_q[W-1].ax[C-1]}}, dside_q[W-1].ax} + offx;
    sumy  = {{2{dside_q[W-1].ay[C-1]}}, dside_q[W-1].ay} + offy;
    cx7_d = sumx[C-1:0];
    cy7_d = sumy[C-1:0];
  end

  logic         hit7_q;
  logic [C-1:0] cx7_q, cy7_q;
  logic [P-1:0] sqx7_q, sqy7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit7_q <= dside_q[W-1].hit;
      cx7_q  <= cx7_d;
      cy7_q  <= cy7_d;
      sqx7_q <= qx * qx;
      sqy7_q <= qy * qy;
    end
  end

  // sum of squares; fits P bits since each offset is at most 2^C
  logic [P:0] ssum;
  assign ssum = {1'b0, sqx7_q} + {1'b0, sqy7_q};

  typedef struct packed {
    logic         hit;
    logic [C-1:0] cx;
    logic [C-1:0] cy;
  } sqrt_side_t;

  logic [P-1:0] ssum8_q;
  sqrt_side_t   side8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ssum8_q <= ssum[P-1:0];
      side8_q <= '{hit: hit7_q, cx: cx7_q, cy: cy7_q};
    end
  end

  // square root stages, one per root bit
  logic [W-1:0] root;

  sidu_sqrt #(.W(W)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .sq_i   (ssum8_q),
    .root_o (root)
  );

  sqrt_side_t sside_q [W];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sside_q[0] <= side8_q;
      for (int unsigned k = 1; k < W; k++) begin
        sside_q[k] <= sside_q[k-1];
      end
    end
  end

  // output register; a miss reports a zero point and all-ones distance
  logic         hit_q;
  logic [C-1:0] cx_q, cy_q;
  logic [W-1:0] dist_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q  <= sside_q[W-1].hit;
      cx_q   <= sside_q[W-1].hit ? sside_q[W-1].cx : '0;
      cy_q   <= sside_q[W-1].hit ? sside_q[W-1].cy : '0;
      dist_q <= sside_q[W-1].hit ? root : '1;
    end
  end

  assign out_o.valid           = vld_q[SOut];
  assign out_o.hit             = hit_q;
  assign out_o.cross_x         = cx_q;
  assign out_o.cross_y         = cy_q;
  assign out_o.dist_from_start = dist_q;

  // a hit beat in the range stage always has a nonzero denominator
  `SIDU_ASSERT_IMP(a_hit_nonzero_den, vld_q[3] && hit4_q, dm4_q != '0)
  // miss beats carry the fixed miss pattern
  `SIDU_ASSERT_IMP(a_miss_pattern, out_o.valid && !out_o.hit,
    out_o.dist_from_start == '1 && out_o.cross_x == '0 && out_o.cross_y == '0)
  // a true distance is below sqrt(2)*2^C and never reaches all ones
  `SIDU_ASSERT_IMP(a_hit_dist_range, out_o.valid && out_o.hit, out_o.dist_from_start != '1)
  // a stall freezes the whole valid chain
  `SIDU_ASSERT_NXT(a_stall_freeze, out_o.valid && !out_o.ready, $stable(vld_q))
  // squared offsets of a hit never carry out of the product width
  `SIDU_ASSERT_IMP(a_sum_no_carry, vld_q[SPost] && hit7_q, !ssum[P])

endmodule
